// ===== hw/rtl/mczs_pkg.sv =====
`default_nettype none

package mczs_pkg;

    // Fixed field widths.
    localparam int unsigned KIND_W = 3;
    localparam int unsigned ZONE_W = 6;
    localparam int unsigned SEC_W  = 16;
    localparam int unsigned EV_W   = 2;
    localparam int unsigned ERR_W  = 2;
    localparam int unsigned MASK_W = 8;
    localparam int unsigned TDATA_W = 40;

    // Input item kinds.
    localparam logic [KIND_W-1:0] KIND_ON    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_OFF   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TICK  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STOP  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_QUERY = 3'd4;

    // Result event codes.
    localparam logic [EV_W-1:0] EV_REPLY     = 2'd0;
    localparam logic [EV_W-1:0] EV_EXPIRED   = 2'd1;
    localparam logic [EV_W-1:0] EV_TICK_DONE = 2'd2;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
    localparam logic [ERR_W-1:0] ERR_ZONE     = 2'd1;
    localparam logic [ERR_W-1:0] ERR_DURATION = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_MIN_DURATION = 1'b0;
    localparam logic CFG_MAX_DURATION = 1'b1;

    // Register reset values.
    localparam logic [SEC_W-1:0] MIN_DURATION_RST = 16'd1;
    localparam logic [SEC_W-1:0] MAX_DURATION_RST = 16'd3600;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_REPLY,
        ST_TICK,
        ST_EMIT,
        ST_DONE
    } t_state;

    // One result item, apart from the relay mask.
    typedef struct packed {
        logic [EV_W-1:0]   ev;
        logic [ZONE_W-1:0] zone;
        logic              act;
        logic [SEC_W-1:0]  rem;
        logic [ERR_W-1:0]  err;
        logic              last;
    } t_res;

endpackage

`default_nettype wire

// ===== hw/rtl/mczs_mem.sv =====
`default_nettype none

module mczs_mem
    import mczs_pkg::*;
#(
    parameter int unsigned DEPTH = 8,
    parameter int unsigned AW    = 3
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [AW-1:0]    i_raddr,
    output      logic [SEC_W-1:0] o_rdata,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [SEC_W-1:0] i_wdata,
    input  wire logic             i_clr_all
);

    logic [SEC_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [SEC_W-1:0] r_rdata;
    logic             r_rvld;

    // Seconds store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    // Per-entry valid bits; an entry never written since reset or stop reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            r_rvld <= r_vld[i_raddr];
            if (i_clr_all) begin
                r_vld <= '0;
            end else if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/mczs_engine.sv =====
`default_nettype none

module mczs_engine
    import mczs_pkg::*;
#(
    parameter int unsigned ZONES = 8,
    parameter int unsigned AW    = 3
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Input items.
    input  wire logic              i_in_valid,
    output      logic              o_in_ready,
    input  wire logic [KIND_W-1:0] i_kind,
    input  wire logic [ZONE_W-1:0] i_zone,
    input  wire logic [SEC_W-1:0]  i_dur,
    input  wire logic [SEC_W-1:0]  i_el,
    // Duration limits.
    input  wire logic [SEC_W-1:0]  i_min_dur,
    input  wire logic [SEC_W-1:0]  i_max_dur,
    // Result items.
    output      logic              o_out_valid,
    input  wire logic              i_out_ready,
    output      t_res              o_res,
    output      logic [MASK_W-1:0] o_mask,
    // Seconds store.
    output      logic [AW-1:0]     o_raddr,
    input  wire logic [SEC_W-1:0]  i_rdata,
    output      logic              o_we,
    output      logic [AW-1:0]     o_waddr,
    output      logic [SEC_W-1:0]  o_wdata,
    output      logic              o_clr_all
);

    localparam logic [AW-1:0]     LAST_IDX  = AW'(ZONES - 1);
    localparam logic [ZONE_W-1:0] ZONE_MAX  = ZONE_W'(ZONES);

    t_state            r_state, n_state;
    logic [KIND_W-1:0] r_kind;
    logic [ZONE_W-1:0] r_zone;
    logic [SEC_W-1:0]  r_dur, r_el;
    logic [AW-1:0]     r_idx, n_idx;
    logic [ZONES-1:0]  r_on, n_on;
    logic [ZONES-1:0]  r_exp, n_exp;
    t_res              r_cmd, n_cmd;
    logic              r_ov, n_ov;
    t_res              r_ores, n_ores;
    logic [MASK_W-1:0] r_omask, n_omask;

    logic                  accept;
    logic                  out_free;
    logic                  zone_ok;
    logic [AW-1:0]         zidx;
    logic [ZONE_W-1:0]     zone_m1;
    logic [ZONES+MASK_W-1:0] on_pad;
    logic [MASK_W-1:0]     mask_now;

    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_ov || i_out_ready;
    assign zone_m1  = r_zone - ZONE_W'(1);
    assign zidx     = zone_m1[AW-1:0];
    assign zone_ok  = (r_zone != '0) && (r_zone <= ZONE_MAX);
    assign on_pad   = {{MASK_W{1'b0}}, r_on};
    assign mask_now = on_pad[MASK_W-1:0];

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_kind == KIND_TICK) ? ST_TICK : ST_CMD;
                end
            end
            ST_CMD: n_state = ST_REPLY;
            ST_REPLY: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_TICK: begin
                if (r_idx == LAST_IDX) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (r_idx == LAST_IDX && (!r_exp[r_idx] || out_free)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and memory control for each state.
    always_comb begin
        logic [ZONE_W-1:0] zone_p1;
        zone_p1   = ZONE_W'(r_idx) + ZONE_W'(1);
        n_idx     = r_idx;
        n_on      = r_on;
        n_exp     = r_exp;
        n_cmd     = r_cmd;
        n_ov      = r_ov && !i_out_ready;
        n_ores    = r_ores;
        n_omask   = r_omask;
        o_raddr   = r_idx + AW'(1);
        o_we      = 1'b0;
        o_waddr   = r_idx;
        o_wdata   = '0;
        o_clr_all = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                // Start the read of the addressed zone, or of zone 1 for a tick.
                if (i_kind == KIND_TICK) begin
                    o_raddr = '0;
                end else begin
                    o_raddr = AW'(i_zone - ZONE_W'(1));
                end
                if (accept) begin
                    n_idx = '0;
                    n_exp = '0;
                end
            end
            ST_CMD: begin
                // Apply a command to the zone whose seconds are now on the read port.
                n_cmd = '{ev: EV_REPLY, zone: '0, act: 1'b0, rem: '0, err: ERR_OK,
                          last: 1'b1};
                o_waddr = zidx;
                priority if (r_kind == KIND_STOP) begin
                    o_clr_all = 1'b1;
                    n_on      = '0;
                end else if (r_kind != KIND_ON && r_kind != KIND_OFF
                             && r_kind != KIND_QUERY) begin
                    n_cmd.err = ERR_OK;
                end else if (!zone_ok) begin
                    n_cmd.err = ERR_ZONE;
                end else begin
                    n_cmd.zone = r_zone;
                    n_cmd.act  = r_on[zidx];
                    n_cmd.rem  = i_rdata;
                    if (r_kind == KIND_ON) begin
                        if (r_dur < i_min_dur || r_dur > i_max_dur) begin
                            n_cmd.err = ERR_DURATION;
                        end else begin
                            o_we        = 1'b1;
                            o_wdata     = r_dur;
                            n_on[zidx]  = 1'b1;
                            n_cmd.act   = 1'b1;
                            n_cmd.rem   = r_dur;
                        end
                    end else if (r_kind == KIND_OFF) begin
                        o_we       = 1'b1;
                        o_wdata    = '0;
                        n_on[zidx] = 1'b0;
                        n_cmd.act  = 1'b0;
                        n_cmd.rem  = '0;
                    end
                end
            end
            ST_REPLY: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_ores  = r_cmd;
                    n_omask = mask_now;
                end
            end
            ST_TICK: begin
                // Count down one running timer per cycle and mark expiries.
                if (i_rdata != '0) begin
                    o_we = 1'b1;
                    if (i_rdata <= r_el) begin
                        o_wdata       = '0;
                        n_on[r_idx]   = 1'b0;
                        n_exp[r_idx]  = 1'b1;
                    end else begin
                        o_wdata = i_rdata - r_el;
                    end
                end
                n_idx = (r_idx == LAST_IDX) ? '0 : r_idx + AW'(1);
            end
            ST_EMIT: begin
                // Report expired zones in ascending order once the mask is final.
                if (!r_exp[r_idx]) begin
                    n_idx = r_idx + AW'(1);
                end else if (out_free) begin
                    n_ov    = 1'b1;
                    n_ores  = '{ev: EV_EXPIRED, zone: zone_p1, act: 1'b0, rem: '0,
                                err: ERR_OK, last: 1'b0};
                    n_omask = mask_now;
                    n_idx   = r_idx + AW'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_ores  = '{ev: EV_TICK_DONE, zone: '0, act: 1'b0, rem: '0,
                                err: ERR_OK, last: 1'b1};
                    n_omask = mask_now;
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_on    <= '0;
            r_exp   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_on    <= n_on;
            r_exp   <= n_exp;
            r_ov    <= n_ov;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_kind;
            r_zone <= i_zone;
            r_dur  <= i_dur;
            r_el   <= i_el;
        end
        r_cmd   <= n_cmd;
        r_ores  <= n_ores;
        r_omask <= n_omask;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_ov;
    assign o_res       = r_ores;
    assign o_mask      = r_omask;

`ifndef SYNTHESIS
    a_err_only_in_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ores.err != ERR_OK) |-> (r_ores.ev == EV_REPLY))
        else $error("error code on a result that is not a command reply");

    a_expiry_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ores.ev == EV_EXPIRED) |-> (!r_ores.last && r_ores.zone != '0))
        else $error("expiry result marked last or without a zone");

    a_tick_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ores.ev == EV_TICK_DONE) |-> r_ores.last)
        else $error("tick finished result not marked last");

    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMD && r_kind == KIND_STOP) |=> (r_on == '0))
        else $error("zones still on after stop all");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!o_we && !o_clr_all))
        else $error("seconds store written while idle");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/multi_zone_countdown_switch.sv =====
// Multi-zone countdown switch: an on flag and a seconds countdown per zone.
// Input channel (s_axis): one item per command or tick. The kind travels in
// tuser; zone, duration and elapsed seconds travel in tdata.
// Output channel (m_axis): result items; the event code travels in tuser and
// tlast marks the final result of an input item. Every result carries the
// relay mask as it stands after the whole input item.
// Configuration channel (i_cfg_*): index 0 writes min_duration, index 1 writes
// max_duration; always ready. Write only while no item is in flight.
// A command passes these steps from acceptance to its result on m_axis:
// accept and read, modify and write back, load output register.
// A tick walks the seconds memory once to count down, then walks the
// expiry flags to report, then gives the tick finished result.
// One item is worked on at a time; the next is accepted once the last result
// of the current one is loaded into the output register.
// When the receiver stalls, the output register holds its result and the
// walk waits on each result it has to emit.
// Reset clears all zones to off with zero seconds and loads the duration
// limits with 1 and 3600 seconds.
`default_nettype none

module multi_zone_countdown_switch
    import mczs_pkg::*;
#(
    parameter int unsigned ZONES = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Input items.
    input  wire logic               s_axis_tvalid,
    output      logic               s_axis_tready,
    // tdata: zone[5:0], duration_sec[21:6], elapsed_sec[37:22], zero pad.
    input  wire logic [TDATA_W-1:0] s_axis_tdata,
    // tuser: kind[2:0].
    input  wire logic [KIND_W-1:0]  s_axis_tuser,
    // Result items.
    output      logic               m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // tdata: zone_out[5:0], active[6], remaining_sec[22:7], error[24:23],
    // relay_mask[32:25], zero pad.
    output      logic [TDATA_W-1:0] m_axis_tdata,
    // tuser: event_res[1:0].
    output      logic [EV_W-1:0]    m_axis_tuser,
    output      logic               m_axis_tlast,
    // Configuration writes.
    input  wire logic               i_cfg_valid,
    output      logic               o_cfg_ready,
    input  wire logic               i_cfg_index,
    input  wire logic [SEC_W-1:0]   i_cfg_data
);

    localparam int unsigned AW = (ZONES > 1) ? $clog2(ZONES) : 1;

    logic [SEC_W-1:0]  r_min_dur, r_max_dur;
    logic [AW-1:0]     raddr, waddr;
    logic [SEC_W-1:0]  rdata, wdata;
    logic              we, clr_all;
    t_res              res;
    logic [MASK_W-1:0] mask;

    // Duration limit registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dur <= MIN_DURATION_RST;
            r_max_dur <= MAX_DURATION_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MIN_DURATION: r_min_dur <= i_cfg_data;
                CFG_MAX_DURATION: r_max_dur <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    mczs_mem #(
        .DEPTH (ZONES),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_raddr   (raddr),
        .o_rdata   (rdata),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_clr_all (clr_all)
    );

    mczs_engine #(
        .ZONES (ZONES),
        .AW    (AW)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_kind      (s_axis_tuser),
        .i_zone      (s_axis_tdata[5:0]),
        .i_dur       (s_axis_tdata[21:6]),
        .i_el        (s_axis_tdata[37:22]),
        .i_min_dur   (r_min_dur),
        .i_max_dur   (r_max_dur),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_res       (res),
        .o_mask      (mask),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_clr_all   (clr_all)
    );

    // Result packing.
    assign m_axis_tdata = {7'd0, mask, res.err, res.rem, res.act, res.zone};
    assign m_axis_tuser = res.ev;
    assign m_axis_tlast = res.last;

endmodule

`default_nettype wire
